// File: hdl/dns_query_redirect_responder_defines.svh
// Assertion macros for the DNS redirect responder
`ifndef DNS_QUERY_REDIRECT_RESPONDER_DEFINES_SVH
`define DNS_QUERY_REDIRECT_RESPONDER_DEFINES_SVH

// same-cycle implication under synchronous reset
`define DQR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication under synchronous reset
`define DQR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/dqr_pkg.sv
// Shared constants, types and byte functions of the DNS redirect responder
package dqr_pkg;

    localparam int MAX_PACKET = 512;
    localparam int POS_W      = 10;
    localparam int CNT_W      = 11;

    localparam logic [POS_W-1:0] POS_MAX       = 10'd1023;
    localparam logic [POS_W-1:0] POS_LAST_HDR  = 10'd11;
    localparam logic [CNT_W-1:0] ANSWER_LEN    = 11'd17;
    localparam logic [CNT_W-1:0] MAX_PACKET_W  = CNT_W'(MAX_PACKET);
    localparam logic [2:0]       TAIL_START    = 3'd4;
    localparam logic [2:0]       TAIL_ABORTED  = 3'd7;
    localparam logic [3:0]       ANS_IDX_LAST  = 4'd15;

    localparam logic [31:0] ADDR_RESET = 32'hC0A8_0401;
    localparam logic [31:0] TTL_RESET  = 32'd60;

    // configuration register indexes
    localparam logic REG_ANSWER_ADDRESS = 1'b0;
    localparam logic REG_ANSWER_TTL     = 1'b1;

    typedef struct packed {
        logic       emit;
        logic [7:0] out_byte;
        logic       out_last;
        logic       out_abort;
        logic       answer;
    } t_parse_res;

    typedef struct packed {
        logic can_take;
        logic ans_active;
    } t_emit_status;

    // rewrite of the 12 header bytes: flags 0x8180, one answer, no others
    function automatic logic [7:0] header_byte(input logic [POS_W-1:0] pos,
                                               input logic [7:0] b);
        logic [7:0] r;
        case (pos)
            10'd2:   r = 8'h81;
            10'd3:   r = 8'h80;
            10'd6:   r = 8'h00;
            10'd7:   r = 8'h01;
            10'd8:   r = 8'h00;
            10'd9:   r = 8'h00;
            10'd10:  r = 8'h00;
            10'd11:  r = 8'h00;
            default: r = b;
        endcase
        return r;
    endfunction

    // answer record: name pointer, type A, class IN, TTL, length 4, address
    function automatic logic [7:0] answer_byte(input logic [3:0] idx,
                                               input logic [31:0] ttl,
                                               input logic [31:0] addr);
        logic [7:0] r;
        case (idx)
            4'd0:    r = 8'hC0;
            4'd1:    r = 8'h0C;
            4'd2:    r = 8'h00;
            4'd3:    r = 8'h01;
            4'd4:    r = 8'h00;
            4'd5:    r = 8'h01;
            4'd6:    r = ttl[31:24];
            4'd7:    r = ttl[23:16];
            4'd8:    r = ttl[15:8];
            4'd9:    r = ttl[7:0];
            4'd10:   r = 8'h00;
            4'd11:   r = 8'h04;
            4'd12:   r = addr[31:24];
            4'd13:   r = addr[23:16];
            4'd14:   r = addr[15:8];
            default: r = addr[7:0];
        endcase
        return r;
    endfunction

endpackage

// File: hdl/dqr_ifs.sv
// Handshake interfaces for query, response and configuration channels

interface dqr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;
    modport source (output valid, in_byte, in_last, input ready);
    modport sink   (input valid, in_byte, in_last, output ready);
endinterface

interface dqr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_last;
    logic       out_abort;
    modport source (output valid, out_byte, out_last, out_abort, input ready);
    modport sink   (input valid, out_byte, out_last, out_abort, output ready);
endinterface

interface dqr_cfg_if;
    logic        valid;
    logic        ready;
    logic        index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: hdl/dqr_parser.sv
// Query walker: tracks header, name labels and type/class bytes per beat
module dqr_parser
    import dqr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_take,
    input  logic [7:0] i_byte,
    input  logic       i_last,
    output t_parse_res o_res
);

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_NAME   = 2'd1,
        PH_TAIL   = 2'd2,
        PH_DONE   = 2'd3
    } t_phase;

    t_phase           r_phase, n_phase;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [7:0]       r_skip, n_skip;
    logic [2:0]       r_tail, n_tail;

    logic       overflow;
    logic       restart;
    logic [2:0] tail_dec;

    assign overflow = ({1'b0, r_pos} + ANSWER_LEN) > MAX_PACKET_W;
    assign tail_dec = (r_tail != 3'd0) ? r_tail - 3'd1 : r_tail;

    always_comb begin
        n_phase = r_phase;
        n_pos   = r_pos;
        n_skip  = r_skip;
        n_tail  = r_tail;
        restart = 1'b0;
        o_res   = '0;
        if (i_take) begin
            n_pos = (r_pos == POS_MAX) ? r_pos : r_pos + 10'd1;
            case (r_phase)
                PH_HEADER: begin
                    if (i_last) begin
                        o_res.emit      = 1'b1;
                        o_res.out_last  = 1'b1;
                        o_res.out_abort = 1'b1;
                        restart         = 1'b1;
                    end else begin
                        o_res.emit     = 1'b1;
                        o_res.out_byte = header_byte(r_pos, i_byte);
                        if (r_pos >= POS_LAST_HDR) begin
                            n_phase = PH_NAME;
                        end
                    end
                end
                PH_DONE: begin
                    if (i_last) begin
                        o_res.answer = (r_tail != TAIL_ABORTED);
                        restart      = 1'b1;
                    end
                end
                default: begin
                    if (overflow) begin
                        o_res.emit      = 1'b1;
                        o_res.out_last  = 1'b1;
                        o_res.out_abort = 1'b1;
                        if (i_last) begin
                            restart = 1'b1;
                        end else begin
                            n_phase = PH_DONE;
                            n_tail  = TAIL_ABORTED;
                        end
                    end else begin
                        if (r_phase == PH_NAME) begin
                            if (r_skip != 8'd0) begin
                                n_skip = r_skip - 8'd1;
                            end else if (i_byte == 8'd0) begin
                                n_phase = PH_TAIL;
                                n_tail  = TAIL_START;
                            end else begin
                                n_skip = i_byte;
                            end
                        end else begin
                            n_tail = tail_dec;
                            if (tail_dec == 3'd0) begin
                                n_phase = PH_DONE;
                            end
                        end
                        o_res.emit = 1'b1;
                        if (i_last) begin
                            restart = 1'b1;
                            if (n_phase == PH_DONE) begin
                                o_res.out_byte = i_byte;
                                o_res.answer   = 1'b1;
                            end else begin
                                // question cut short: abort instead of the byte
                                o_res.out_last  = 1'b1;
                                o_res.out_abort = 1'b1;
                            end
                        end else begin
                            o_res.out_byte = i_byte;
                        end
                    end
                end
            endcase
            if (restart) begin
                n_phase = PH_HEADER;
                n_pos   = '0;
                n_skip  = '0;
                n_tail  = TAIL_START;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
            r_pos   <= '0;
            r_skip  <= '0;
            r_tail  <= TAIL_START;
        end else begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_skip  <= n_skip;
            r_tail  <= n_tail;
        end
    end

endmodule

// File: hdl/dqr_emitter.sv
// Response output register and answer record sequencer
module dqr_emitter
    import dqr_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_take,
    input  t_parse_res   i_res,
    input  logic [31:0]  i_addr,
    input  logic [31:0]  i_ttl,
    output t_emit_status o_status,
    dqr_out_if.source    o_out
);

    logic       r_valid, n_valid;
    logic [7:0] r_byte, n_byte;
    logic       r_last, n_last;
    logic       r_abort, n_abort;
    logic       r_ans_active, n_ans_active;
    logic [3:0] r_idx, n_idx;
    logic       slot_free;

    assign slot_free         = !r_valid || o_out.ready;
    assign o_status.can_take = slot_free && !r_ans_active;
    assign o_status.ans_active = r_ans_active;

    always_comb begin
        n_valid      = r_valid;
        n_byte       = r_byte;
        n_last       = r_last;
        n_abort      = r_abort;
        n_ans_active = r_ans_active;
        n_idx        = r_idx;
        if (r_valid && o_out.ready) begin
            n_valid = 1'b0;
        end
        if (i_take) begin
            if (i_res.emit) begin
                n_valid = 1'b1;
                n_byte  = i_res.out_byte;
                n_last  = i_res.out_last;
                n_abort = i_res.out_abort;
            end
            if (i_res.answer) begin
                n_ans_active = 1'b1;
                n_idx        = '0;
            end
        end else if (r_ans_active && slot_free) begin
            // advance one answer byte per free output slot
            n_valid = 1'b1;
            n_byte  = answer_byte(r_idx, i_ttl, i_addr);
            n_last  = (r_idx == ANS_IDX_LAST);
            n_abort = 1'b0;
            n_idx   = r_idx + 4'd1;
            if (r_idx == ANS_IDX_LAST) begin
                n_ans_active = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_ans_active <= 1'b0;
            r_idx        <= '0;
        end else begin
            r_valid      <= n_valid;
            r_ans_active <= n_ans_active;
            r_idx        <= n_idx;
        end
        r_byte  <= n_byte;
        r_last  <= n_last;
        r_abort <= n_abort;
    end

    assign o_out.valid     = r_valid;
    assign o_out.out_byte  = r_byte;
    assign o_out.out_last  = r_last;
    assign o_out.out_abort = r_abort;

endmodule

// File: hdl/dns_query_redirect_responder.sv
// Top level of the DNS redirect responder: config registers, walker, emitter
//
// Takes a DNS query one byte per beat and returns a response that answers
// it with the configured IPv4 address and TTL. Header and question bytes
// go out the cycle after they are taken, so query bytes stream at one per
// cycle unless stalled. On a frame's last byte the 16-byte answer record
// follows from a sequencer behind the single output register: the input
// stalls meanwhile, also when the question ended before the last byte,
// then takes bytes again. A malformed or oversized query yields one abort
// beat with out_last and out_abort set; discard that frame's earlier
// output. Write configuration only while no response is in flight.
`include "dns_query_redirect_responder_defines.svh"

module dns_query_redirect_responder
    import dqr_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    dqr_in_if.sink    i_in,
    dqr_out_if.source o_out,
    dqr_cfg_if.sink   i_cfg
);

    logic [31:0]  r_addr;
    logic [31:0]  r_ttl;
    logic         take;
    t_parse_res   res;
    t_emit_status status;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr <= ADDR_RESET;
            r_ttl  <= TTL_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_ANSWER_ADDRESS: r_addr <= i_cfg.data;
                REG_ANSWER_TTL:     r_ttl  <= i_cfg.data;
                default:            r_addr <= r_addr;
            endcase
        end
    end

    assign i_in.ready = status.can_take;
    assign take       = i_in.valid && status.can_take;

    dqr_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_byte  (i_in.in_byte),
        .i_last  (i_in.in_last),
        .o_res   (res)
    );

    dqr_emitter u_emitter (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_take   (take),
        .i_res    (res),
        .i_addr   (r_addr),
        .i_ttl    (r_ttl),
        .o_status (status),
        .o_out    (o_out)
    );

    `DQR_ASSERT_NOW(a_no_take_during_answer, take, !status.ans_active,
                    "byte taken during answer")
    `DQR_ASSERT_NEXT(a_answer_starts, take && res.answer, status.ans_active,
                     "answer did not start")
    `DQR_ASSERT_NOW(a_abort_is_last, o_out.valid && o_out.out_abort,
                    o_out.out_last && (o_out.out_byte == 8'd0), "malformed abort beat")
    `DQR_ASSERT_NOW(a_answer_no_abort, take && res.answer, !res.out_abort,
                    "answer with abort")

endmodule
